// ===== rtl/ansi_csi_sgr_decoder_assert.svh =====
// assertion macros for the sgr decoder
`ifndef ANSI_CSI_SGR_DECODER_ASSERT_SVH
`define ANSI_CSI_SGR_DECODER_ASSERT_SVH

// checked outside reset
`define CSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define CSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/csi_sgr_pkg.sv =====
`default_nettype none
package csi_sgr_pkg;

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  typedef enum logic [4:0] {
    EXT_NONE   = 5'b00001,
    EXT_FG_SEL = 5'b00010,
    EXT_BG_SEL = 5'b00100,
    EXT_FG_IDX = 5'b01000,
    EXT_BG_IDX = 5'b10000
  } ext_t;

  typedef struct packed {
    logic        fg_valid;
    logic [23:0] fg_rgb;
    logic        bg_valid;
    logic [23:0] bg_rgb;
    logic        bold;
  } fmt_t;

  typedef struct packed {
    logic [15:0] value;
    logic        empty;
    logic        valid;
  } num_t;

  typedef struct packed {
    ext_t ext;
    fmt_t fmt;
  } code_res_t;

  localparam fmt_t FMT_RESET = '0;
  localparam num_t NUM_RESET = '{value: 16'd0, empty: 1'b1, valid: 1'b1};

  localparam logic [7:0] ESC_BYTE      = 8'h1b;
  localparam logic [7:0] CSI_OPEN      = 8'h5b;
  localparam logic [7:0] SEP_BYTE      = 8'h3b;
  localparam logic [7:0] DIGIT_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI      = 8'h39;
  localparam logic [7:0] FINAL_LO      = 8'h40;
  localparam logic [7:0] FINAL_HI      = 8'h7e;
  localparam logic [7:0] FIN_SGR       = 8'h6d;
  localparam logic [7:0] FIN_PREV_LINE = 8'h46;
  localparam logic [7:0] FIN_ERASE     = 8'h4a;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_ERASE = 1'b1;

  localparam logic [15:0] VALUE_MAX       = 16'hffff;
  localparam logic [15:0] SGR_RESET       = 16'd0;
  localparam logic [15:0] SGR_BOLD        = 16'd1;
  localparam logic [15:0] SGR_NORMAL      = 16'd22;
  localparam logic [15:0] SGR_FG_BASE     = 16'd30;
  localparam logic [15:0] SGR_BG_BASE     = 16'd40;
  localparam logic [15:0] SGR_FG_BRIGHT   = 16'd90;
  localparam logic [15:0] SGR_BG_BRIGHT   = 16'd100;
  localparam logic [15:0] SGR_FG_EXT      = 16'd38;
  localparam logic [15:0] SGR_BG_EXT      = 16'd48;
  localparam logic [15:0] SGR_EXT_INDEXED = 16'd5;
  localparam logic [15:0] INDEX_MAX       = 16'd255;
  localparam logic [7:0]  GREY_FIRST      = 8'd232;
  localparam logic [1:0]  ERASE_MODE_MAX  = 2'd2;

  function automatic logic [23:0] normal_pal(input logic [2:0] i);
    logic [23:0] rgb;
    case (i)
      3'd0: rgb = 24'h000000;
      3'd1: rgb = 24'hcd3131;
      3'd2: rgb = 24'h0dbc79;
      3'd3: rgb = 24'he5e510;
      3'd4: rgb = 24'h2472c8;
      3'd5: rgb = 24'hbc3fbc;
      3'd6: rgb = 24'h11a8cd;
      default: rgb = 24'he5e5e5;
    endcase
    return rgb;
  endfunction

  function automatic logic [23:0] bright_pal(input logic [2:0] i);
    logic [23:0] rgb;
    case (i)
      3'd0: rgb = 24'h666666;
      3'd1: rgb = 24'hf14c4c;
      3'd2: rgb = 24'h23d18b;
      3'd3: rgb = 24'hf5f543;
      3'd4: rgb = 24'h3b8eea;
      3'd5: rgb = 24'hd670d6;
      3'd6: rgb = 24'h29b8db;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] v);
    logic [7:0] l;
    case (v)
      3'd1: l = 8'd95;
      3'd2: l = 8'd135;
      3'd3: l = 8'd175;
      3'd4: l = 8'd215;
      3'd5: l = 8'd255;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

  // 256 colour index: 6x6x6 cube below the grey ramp
  function automatic logic [23:0] indexed_rgb(input logic [7:0] n);
    logic [2:0] q;
    logic [7:0] rem;
    logic [2:0] gi;
    logic [2:0] bi;
    logic [2:0] ri;
    logic [7:0] g;
    logic [7:0] l;
    q = (n >= 8'd216) ? 3'd6 : (n >= 8'd180) ? 3'd5 : (n >= 8'd144) ? 3'd4 :
        (n >= 8'd108) ? 3'd3 : (n >= 8'd72) ? 3'd2 : (n >= 8'd36) ? 3'd1 : 3'd0;
    rem = n - ({5'd0, q} * 8'd36);
    gi = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
         (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6) ? 3'd1 : 3'd0;
    bi = 3'(rem - ({5'd0, gi} * 8'd6));
    ri = (q == 3'd6) ? 3'd0 : q;
    g = n - GREY_FIRST;
    l = 8'd8 + (g * 8'd10);
    if (n >= GREY_FIRST) begin
      return {l, l, l};
    end
    return {cube_level(ri), cube_level(gi), cube_level(bi)};
  endfunction

  function automatic num_t feed_number(input num_t cur, input logic [7:0] b);
    num_t nx;
    logic [19:0] nv;
    nx = cur;
    nx.empty = 1'b0;
    nv = ({4'd0, cur.value} * 20'd10) + {16'd0, b[3:0]};
    if (b inside {[DIGIT_LO:DIGIT_HI]}) begin
      if (cur.valid) begin
        nx.value = (nv > {4'd0, VALUE_MAX}) ? VALUE_MAX : nv[15:0];
      end
    end else begin
      nx.valid = 1'b0;
    end
    return nx;
  endfunction

  function automatic logic [15:0] number_of(input num_t n);
    return n.valid ? n.value : 16'd0;
  endfunction

  function automatic code_res_t apply_code(input ext_t ext, input fmt_t f,
                                           input logic [15:0] c);
    code_res_t r;
    logic [23:0] rgb;
    r.ext = EXT_NONE;
    r.fmt = f;
    rgb = indexed_rgb(c[7:0]);
    if (ext == EXT_FG_IDX || ext == EXT_BG_IDX) begin
      if (c <= INDEX_MAX) begin
        if (ext == EXT_FG_IDX) begin
          r.fmt.fg_valid = 1'b1;
          r.fmt.fg_rgb = rgb;
        end else begin
          r.fmt.bg_valid = 1'b1;
          r.fmt.bg_rgb = rgb;
        end
      end
    end else if ((ext == EXT_FG_SEL || ext == EXT_BG_SEL) && c == SGR_EXT_INDEXED) begin
      r.ext = (ext == EXT_FG_SEL) ? EXT_FG_IDX : EXT_BG_IDX;
    end else if (c == SGR_RESET) begin
      r.fmt = FMT_RESET;
    end else if (c == SGR_BOLD) begin
      r.fmt.bold = 1'b1;
    end else if (c == SGR_NORMAL) begin
      r.fmt.bold = 1'b0;
    end else if (c inside {[SGR_FG_BASE:SGR_FG_BASE + 16'd7]}) begin
      r.fmt.fg_valid = 1'b1;
      r.fmt.fg_rgb = normal_pal(3'(c - SGR_FG_BASE));
    end else if (c inside {[SGR_BG_BASE:SGR_BG_BASE + 16'd7]}) begin
      r.fmt.bg_valid = 1'b1;
      r.fmt.bg_rgb = normal_pal(3'(c - SGR_BG_BASE));
    end else if (c inside {[SGR_FG_BRIGHT:SGR_FG_BRIGHT + 16'd7]}) begin
      r.fmt.fg_valid = 1'b1;
      r.fmt.fg_rgb = bright_pal(3'(c - SGR_FG_BRIGHT));
    end else if (c inside {[SGR_BG_BRIGHT:SGR_BG_BRIGHT + 16'd7]}) begin
      r.fmt.bg_valid = 1'b1;
      r.fmt.bg_rgb = bright_pal(3'(c - SGR_BG_BRIGHT));
    end else if (c == SGR_FG_EXT) begin
      r.ext = EXT_FG_SEL;
    end else if (c == SGR_BG_EXT) begin
      r.ext = EXT_BG_SEL;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ansi_csi_sgr_decoder.sv =====
`default_nettype none
// ANSI CSI / SGR byte-stream decoder.
// Input channel: in_valid, in_stall, in_byte, one raw stream byte per item.
// Output channel: out_valid, out_stall and the result fields. A text byte
// comes out as a kind 0 item with the committed colours, weight and any
// pending overwrite count; a 'J' with mode 0 to 2 comes out as a kind 1
// erase item. Escape sequences and all other bytes produce no item.
// Timing: an accepted byte is held in the input register, decoded
// combinationally from there, and its result is loaded into the output
// register.
// Throughput is one byte per cycle while no stall holds the flow; the parser
// state is read and written as each byte is decoded, which sets the rate.
// Reset (rst, synchronous) empties both registers, returns the parser to
// text, clears the pending overwrite count and sets no colours, normal weight.
// When the receiver stalls, the result holds; the input register drains into
// it as soon as it is free, and in_stall rises only when the input register
// holds a result-producing byte that cannot move on. Bytes with no result
// always move on.
module ansi_csi_sgr_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       text_byte,
  output logic             fg_valid,
  output logic [23:0]      fg_rgb,
  output logic             bg_valid,
  output logic [23:0]      bg_rgb,
  output logic             bold,
  output logic [7:0]       overwrite_lines,
  output logic [1:0]       erase_mode
);
  import csi_sgr_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;

  phase_t phase, phase_next;
  num_t   part, part_next;
  num_t   whole, whole_next;
  ext_t   ext, ext_next;
  logic   any_seen, any_seen_next;
  fmt_t   shadow, shadow_next;
  fmt_t   committed, committed_next;
  logic [7:0] ow, ow_next;

  logic       res_hit;
  logic       res_kind;
  logic [7:0] res_byte;
  fmt_t       res_fmt;
  logic [7:0] res_ow;
  logic [1:0] res_mode;

  code_res_t  code_res;
  ext_t       fin_ext;
  fmt_t       fin_fmt;
  logic       fin_any;
  logic [15:0] whole_num;

  // closing the current part
  always_comb begin
    code_res = apply_code(ext, shadow, number_of(part));
    if (!part.empty) begin
      fin_ext = code_res.ext;
      fin_fmt = code_res.fmt;
      fin_any = 1'b1;
    end else begin
      fin_ext = ext;
      fin_fmt = shadow;
      fin_any = any_seen;
    end
    whole_num = number_of(whole);
  end

  always_comb begin
    phase_t cur;
    logic   done;
    cur = phase;
    done = 1'b0;
    phase_next = phase;
    part_next = part;
    whole_next = whole;
    ext_next = ext;
    any_seen_next = any_seen;
    shadow_next = shadow;
    committed_next = committed;
    ow_next = ow;
    res_hit = 1'b0;
    res_kind = KIND_TEXT;
    res_byte = 8'd0;
    res_fmt = FMT_RESET;
    res_ow = 8'd0;
    res_mode = 2'd0;

    if (cur == PH_ESC) begin
      if (s1_byte == CSI_OPEN) begin
        phase_next = PH_CSI;
        part_next = NUM_RESET;
        whole_next = NUM_RESET;
        ext_next = EXT_NONE;
        any_seen_next = 1'b0;
        shadow_next = committed;
        done = 1'b1;
      end else begin
        cur = PH_TEXT;
      end
    end

    if (!done && cur == PH_CSI) begin
      done = 1'b1;
      if (s1_byte inside {[FINAL_LO:FINAL_HI]}) begin
        phase_next = PH_TEXT;
        case (s1_byte)
          FIN_SGR: begin
            part_next = NUM_RESET;
            ext_next = fin_ext;
            any_seen_next = fin_any;
            shadow_next = fin_any ? fin_fmt : FMT_RESET;
            committed_next = fin_any ? fin_fmt : FMT_RESET;
          end
          FIN_PREV_LINE: begin
            if (whole.empty) begin
              ow_next = 8'd1;
            end else begin
              ow_next = (|whole_num[15:8]) ? 8'hff : whole_num[7:0];
            end
          end
          FIN_ERASE: begin
            if (whole.empty || whole_num <= {14'd0, ERASE_MODE_MAX}) begin
              res_hit = 1'b1;
              res_kind = KIND_ERASE;
              res_mode = whole.empty ? 2'd0 : whole_num[1:0];
            end
          end
          default: begin
          end
        endcase
      end else begin
        whole_next = feed_number(whole, s1_byte);
        if (s1_byte == SEP_BYTE) begin
          part_next = NUM_RESET;
          ext_next = fin_ext;
          any_seen_next = fin_any;
          shadow_next = fin_fmt;
        end else begin
          part_next = feed_number(part, s1_byte);
        end
      end
    end

    if (!done) begin
      if (s1_byte == ESC_BYTE) begin
        phase_next = PH_ESC;
      end else begin
        phase_next = PH_TEXT;
        res_hit = 1'b1;
        res_byte = s1_byte;
        res_fmt = committed;
        res_ow = ow;
        ow_next = 8'd0;
      end
    end
  end

  assign adv = s1_valid && (!res_hit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      part <= NUM_RESET;
      whole <= NUM_RESET;
      ext <= EXT_NONE;
      any_seen <= 1'b0;
      shadow <= FMT_RESET;
      committed <= FMT_RESET;
      ow <= 8'd0;
    end else if (adv) begin
      phase <= phase_next;
      part <= part_next;
      whole <= whole_next;
      ext <= ext_next;
      any_seen <= any_seen_next;
      shadow <= shadow_next;
      committed <= committed_next;
      ow <= ow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv && res_hit) begin
      kind <= res_kind;
      text_byte <= res_byte;
      fg_valid <= res_fmt.fg_valid;
      fg_rgb <= res_fmt.fg_valid ? res_fmt.fg_rgb : 24'd0;
      bg_valid <= res_fmt.bg_valid;
      bg_rgb <= res_fmt.bg_valid ? res_fmt.bg_rgb : 24'd0;
      bold <= res_fmt.bold;
      overwrite_lines <= res_ow;
      erase_mode <= res_mode;
    end
  end

`include "ansi_csi_sgr_decoder_assert.svh"

  `CSI_ASSERT(a_erase_clean, out_valid && kind == KIND_ERASE |-> text_byte == 8'd0 && !fg_valid && !bg_valid && !bold && overwrite_lines == 8'd0, "erase item carries text attributes")
  `CSI_ASSERT(a_mode_range, out_valid |-> (kind == KIND_ERASE && erase_mode <= ERASE_MODE_MAX) || (kind == KIND_TEXT && erase_mode == 2'd0), "erase mode out of range")
  `CSI_ASSERT(a_hold_input, s1_valid && !adv |=> s1_valid && $stable(s1_byte), "stalled byte lost")
  `CSI_ASSERT(a_colour_clear, (committed.fg_valid || committed.fg_rgb == 24'd0) && (committed.bg_valid || committed.bg_rgb == 24'd0), "unset colour holds a value")
  `CSI_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !s1_valid && phase == PH_TEXT && ow == 8'd0, "reset left the block busy")

endmodule
`default_nettype wire

// ===== verif/tb_ansi_csi_sgr_decoder.sv =====
`default_nettype none
module tb_ansi_csi_sgr_decoder;
  import csi_sgr_pkg::*;

  localparam int RANDOM_BYTES = 1600;
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic        fg_on;
    logic [23:0] fg;
    logic        bg_on;
    logic [23:0] bg;
    logic        heavy;
    logic [7:0]  lines;
    logic [1:0]  mode;
  } glyph_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  text_byte;
  logic        fg_valid;
  logic [23:0] fg_rgb;
  logic        bg_valid;
  logic [23:0] bg_rgb;
  logic        bold;
  logic [7:0]  overwrite_lines;
  logic [1:0]  erase_mode;

  logic [7:0] stream_bytes[$];
  glyph_t     glyphs_due[$];
  int         accepted = 0;
  int         mismatches = 0;
  int         stuck = 0;
  logic       hold_rx = 1'b0;
  logic       calm;

  // decoder state as seen from the stream
  phase_t     dec_phase;
  num_t       dec_part;
  num_t       dec_whole;
  ext_t       dec_ext;
  logic       dec_seen;
  fmt_t       dec_shadow;
  fmt_t       dec_live;
  logic [7:0] dec_overwrite;

  assign calm = accepted >= 700 && accepted < 1000;

  ansi_csi_sgr_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .text_byte(text_byte),
    .fg_valid(fg_valid),
    .fg_rgb(fg_rgb),
    .bg_valid(bg_valid),
    .bg_rgb(bg_rgb),
    .bold(bold),
    .overwrite_lines(overwrite_lines),
    .erase_mode(erase_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic num_t add_digit(num_t n, logic [7:0] b);
    int acc;
    n.empty = 1'b0;
    if (b >= DIGIT_LO && b <= DIGIT_HI) begin
      if (n.valid) begin
        acc = int'(n.value) * 10 + int'(b - DIGIT_LO);
        n.value = (acc > int'(VALUE_MAX)) ? VALUE_MAX : acc[15:0];
      end
    end else begin
      n.valid = 1'b0;
    end
    return n;
  endfunction

  function automatic int value_of(num_t n);
    return n.valid ? int'(n.value) : 0;
  endfunction

  function automatic logic [7:0] ramp(int v);
    return (v == 0) ? 8'd0 : 8'(55 + 40 * v);
  endfunction

  function automatic logic [23:0] xterm_rgb(int n);
    logic [7:0] l;
    if (n >= int'(GREY_FIRST)) begin
      l = 8'(8 + 10 * (n - int'(GREY_FIRST)));
      return {l, l, l};
    end
    return {ramp((n / 36) % 6), ramp((n / 6) % 6), ramp(n % 6)};
  endfunction

  function automatic logic [23:0] ansi_rgb(logic bright, int i);
    logic [23:0] rgb;
    case ({bright, 3'(i)})
      4'h0: rgb = 24'h000000;
      4'h1: rgb = 24'hcd3131;
      4'h2: rgb = 24'h0dbc79;
      4'h3: rgb = 24'he5e510;
      4'h4: rgb = 24'h2472c8;
      4'h5: rgb = 24'hbc3fbc;
      4'h6: rgb = 24'h11a8cd;
      4'h7: rgb = 24'he5e5e5;
      4'h8: rgb = 24'h666666;
      4'h9: rgb = 24'hf14c4c;
      4'ha: rgb = 24'h23d18b;
      4'hb: rgb = 24'hf5f543;
      4'hc: rgb = 24'h3b8eea;
      4'hd: rgb = 24'hd670d6;
      4'he: rgb = 24'h29b8db;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

  task automatic paint(logic fg, logic [23:0] rgb);
    if (fg) begin
      dec_shadow.fg_valid = 1'b1;
      dec_shadow.fg_rgb = rgb;
    end else begin
      dec_shadow.bg_valid = 1'b1;
      dec_shadow.bg_rgb = rgb;
    end
  endtask

  task automatic apply_sgr(int c);
    if (dec_ext == EXT_FG_IDX || dec_ext == EXT_BG_IDX) begin
      if (c <= int'(INDEX_MAX)) begin
        paint(dec_ext == EXT_FG_IDX, xterm_rgb(c));
      end
      dec_ext = EXT_NONE;
    end else if ((dec_ext == EXT_FG_SEL || dec_ext == EXT_BG_SEL) &&
                 c == int'(SGR_EXT_INDEXED)) begin
      dec_ext = (dec_ext == EXT_FG_SEL) ? EXT_FG_IDX : EXT_BG_IDX;
    end else begin
      dec_ext = EXT_NONE;
      if (c == int'(SGR_RESET)) begin
        dec_shadow = FMT_RESET;
      end else if (c == int'(SGR_BOLD)) begin
        dec_shadow.bold = 1'b1;
      end else if (c == int'(SGR_NORMAL)) begin
        dec_shadow.bold = 1'b0;
      end else if (c >= int'(SGR_FG_BASE) && c <= int'(SGR_FG_BASE) + 7) begin
        paint(1'b1, ansi_rgb(1'b0, c - int'(SGR_FG_BASE)));
      end else if (c >= int'(SGR_BG_BASE) && c <= int'(SGR_BG_BASE) + 7) begin
        paint(1'b0, ansi_rgb(1'b0, c - int'(SGR_BG_BASE)));
      end else if (c >= int'(SGR_FG_BRIGHT) && c <= int'(SGR_FG_BRIGHT) + 7) begin
        paint(1'b1, ansi_rgb(1'b1, c - int'(SGR_FG_BRIGHT)));
      end else if (c >= int'(SGR_BG_BRIGHT) && c <= int'(SGR_BG_BRIGHT) + 7) begin
        paint(1'b0, ansi_rgb(1'b1, c - int'(SGR_BG_BRIGHT)));
      end else if (c == int'(SGR_FG_EXT)) begin
        dec_ext = EXT_FG_SEL;
      end else if (c == int'(SGR_BG_EXT)) begin
        dec_ext = EXT_BG_SEL;
      end
    end
  endtask

  task automatic end_part();
    if (!dec_part.empty) begin
      dec_seen = 1'b1;
      apply_sgr(value_of(dec_part));
    end
    dec_part = NUM_RESET;
  endtask

  task automatic open_sequence();
    dec_part = NUM_RESET;
    dec_whole = NUM_RESET;
    dec_ext = EXT_NONE;
    dec_seen = 1'b0;
    dec_shadow = dec_live;
  endtask

  task automatic decode_byte(logic [7:0] b);
    int     n;
    glyph_t g;
    logic   taken;
    taken = 1'b0;
    g = '0;
    if (dec_phase == PH_ESC) begin
      if (b == CSI_OPEN) begin
        dec_phase = PH_CSI;
        open_sequence();
        taken = 1'b1;
      end else begin
        dec_phase = PH_TEXT;
      end
    end
    if (!taken && dec_phase == PH_CSI) begin
      taken = 1'b1;
      if (b >= FINAL_LO && b <= FINAL_HI) begin
        dec_phase = PH_TEXT;
        if (b == FIN_SGR) begin
          end_part();
          if (!dec_seen) begin
            dec_shadow = FMT_RESET;
          end
          dec_live = dec_shadow;
        end else if (b == FIN_PREV_LINE) begin
          n = dec_whole.empty ? 1 : value_of(dec_whole);
          dec_overwrite = (n > 255) ? 8'd255 : 8'(n);
        end else if (b == FIN_ERASE) begin
          n = dec_whole.empty ? 0 : value_of(dec_whole);
          if (n <= int'(ERASE_MODE_MAX)) begin
            g.kind = KIND_ERASE;
            g.mode = 2'(n);
            glyphs_due.push_back(g);
          end
        end
      end else begin
        dec_whole = add_digit(dec_whole, b);
        if (b == SEP_BYTE) begin
          end_part();
        end else begin
          dec_part = add_digit(dec_part, b);
        end
      end
    end
    if (!taken) begin
      dec_phase = PH_TEXT;
      if (b == ESC_BYTE) begin
        dec_phase = PH_ESC;
      end else begin
        g.kind = KIND_TEXT;
        g.ch = b;
        g.fg_on = dec_live.fg_valid;
        g.fg = dec_live.fg_valid ? dec_live.fg_rgb : 24'd0;
        g.bg_on = dec_live.bg_valid;
        g.bg = dec_live.bg_valid ? dec_live.bg_rgb : 24'd0;
        g.heavy = dec_live.bold;
        g.lines = dec_overwrite;
        dec_overwrite = 8'd0;
        glyphs_due.push_back(g);
      end
    end
  endtask

  function automatic string show(glyph_t g);
    return $sformatf("kind=%0d byte=%02h fg=%0d/%06h bg=%0d/%06h bold=%0d lines=%0d mode=%0d",
                     g.kind, g.ch, g.fg_on, g.fg, g.bg_on, g.bg, g.heavy, g.lines, g.mode);
  endfunction

  function automatic logic differs(glyph_t a, glyph_t b);
    return a.kind !== b.kind || a.ch !== b.ch || a.fg_on !== b.fg_on || a.fg !== b.fg ||
           a.bg_on !== b.bg_on || a.bg !== b.bg || a.heavy !== b.heavy ||
           a.lines !== b.lines || a.mode !== b.mode;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      stream_bytes.push_back(s[i]);
    end
  endtask

  task automatic push_csi(string body);
    stream_bytes.push_back(ESC_BYTE);
    stream_bytes.push_back(CSI_OPEN);
    push_text(body);
  endtask

  function automatic int pick_index();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(256, 70000) : $urandom_range(0, 255);
  endfunction

  function automatic string rand_code();
    case ($urandom_range(0, 11))
      0: return "0";
      1: return "1";
      2: return "22";
      3: return $sformatf("%0d", SGR_FG_BASE + $urandom_range(0, 7));
      4: return $sformatf("%0d", SGR_BG_BASE + $urandom_range(0, 7));
      5: return $sformatf("%0d", SGR_FG_BRIGHT + $urandom_range(0, 7));
      6: return $sformatf("%0d", SGR_BG_BRIGHT + $urandom_range(0, 7));
      7: return $sformatf("%0d;5;%0d", SGR_FG_EXT, pick_index());
      8: return $sformatf("%0d;5;%0d", SGR_BG_EXT, pick_index());
      9: return "";
      10: return $sformatf("%0d", $urandom_range(0, 99999));
      default: return $sformatf("%0d", ($urandom_range(0, 1) != 0) ? SGR_FG_EXT : SGR_BG_EXT);
    endcase
  endfunction

  task automatic push_random_text(int count);
    for (int i = 0; i < count; i++) begin
      stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_random_sgr();
    string body;
    int    codes;
    body = "";
    codes = $urandom_range(0, 4);
    for (int i = 0; i < codes; i++) begin
      body = (i == 0) ? rand_code() : {body, ";", rand_code()};
    end
    push_csi({body, "m"});
  endtask

  task automatic push_noise();
    int count;
    if ($urandom_range(0, 1) != 0) begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      stream_bytes.push_back(ESC_BYTE);
      stream_bytes.push_back(CSI_OPEN);
      count = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) begin
        stream_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8'h3f)) :
                                                             8'($urandom_range(8'h7f, 8'hff)));
      end
      stream_bytes.push_back(8'($urandom_range(FINAL_LO, FINAL_HI)));
    end
  endtask

  task automatic build_stream();
    int target;
    int pick;
    // attribute codes, palettes, extended colours
    push_text("A");
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hff);
    push_csi("1;31;42m");
    push_text("b");
    push_csi("38;5;196;48;5;244m");
    push_text("c");
    push_csi("22;97;107;38;5;16m");
    push_text("d");
    push_csi("m");
    push_text("e");
    // overwrite counts, default and saturated, then erase modes in and out of range
    push_csi("3F");
    push_text("f");
    push_csi("F");
    push_text("g");
    push_csi("99999F");
    push_text("h");
    push_csi("J");
    push_csi("1J");
    push_csi("2J");
    push_csi("3J");
    // lone escape, an escape right before a sequence, then odd and out-of-range codes
    stream_bytes.push_back(ESC_BYTE);
    push_text("x");
    stream_bytes.push_back(ESC_BYTE);
    push_csi("1m");
    push_text("i");
    push_csi("38;2;4m");
    push_text("j");
    push_csi("48;5;300;38;5m");
    push_text("k");
    push_csi("1a;;;32m");
    push_text("l");
    push_csi("70000;1m");
    push_text("n");
    push_csi("0;31h");
    push_text("o");
    target = stream_bytes.size() + RANDOM_BYTES;
    while (stream_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_random_text($urandom_range(1, 6));
      end else if (pick < 70) begin
        push_random_sgr();
        push_random_text(1);
      end else if (pick < 78) begin
        case ($urandom_range(0, 2))
          0: push_csi("F");
          1: push_csi($sformatf("%0dF", $urandom_range(0, 300)));
          default: push_csi($sformatf("%0dF", $urandom_range(0, 99999)));
        endcase
        push_random_text(1);
      end else if (pick < 86) begin
        if ($urandom_range(0, 4) == 0) begin
          push_csi("J");
        end else begin
          push_csi($sformatf("%0dJ", $urandom_range(0, 4)));
        end
      end else begin
        push_noise();
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (stream_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          in_valid <= 1'b1;
          in_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : receiver
    glyph_t got;
    glyph_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = kind;
        got.ch = text_byte;
        got.fg_on = fg_valid;
        got.fg = fg_rgb;
        got.bg_on = bg_valid;
        got.bg = bg_rgb;
        got.heavy = bold;
        got.lines = overwrite_lines;
        got.mode = erase_mode;
        if (glyphs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: %s", show(got));
          end
        end else begin
          want = glyphs_due.pop_front();
          if (differs(want, got)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: want %s", show(want));
              $display("          got  %s", show(got));
            end
          end
        end
      end
      out_stall <= hold_rx || (!calm && $urandom_range(0, 99) < 12);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    dec_phase = PH_TEXT;
    dec_part = NUM_RESET;
    dec_whole = NUM_RESET;
    dec_ext = EXT_NONE;
    dec_seen = 1'b0;
    dec_shadow = FMT_RESET;
    dec_live = FMT_RESET;
    dec_overwrite = 8'd0;
    build_stream();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (stream_bytes.size() != 0 || in_valid || glyphs_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && glyphs_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
